>>> rtl/mfne_pkg.sv
package mfne_pkg;

    // widest supported time word; narrower times are zero-extended in a job
    localparam int TIME_W_MAX = 32;

    localparam logic [30:0] TICK_MAX     = 31'h7FFF_FFFF;
    localparam logic [15:0] RES_AT_RESET = 16'd480;
    localparam logic [7:0]  HDR_LEN      = 8'd6;
    localparam logic [27:0] BPM_NUM      = 28'd120000000;
    localparam logic [25:0] BPM_ZERO     = 26'd60000000;

    // error flag bits
    localparam logic [7:0] E_FILE_ID  = 8'h01;
    localparam logic [7:0] E_HDR_SIZE = 8'h02;
    localparam logic [7:0] E_RES      = 8'h04;
    localparam logic [7:0] E_TRACK_ID = 8'h08;
    localparam logic [7:0] E_EMPTY    = 8'h10;
    localparam logic [7:0] E_UNKNOWN  = 8'h20;
    localparam logic [7:0] E_NO_EVENT = 8'h40;
    localparam logic [7:0] E_NO_OFF   = 8'h80;

    // status nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_POLY     = 4'hA;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_PROG     = 4'hC;
    localparam logic [3:0] ST_CHPR     = 4'hD;
    localparam logic [3:0] ST_BEND     = 4'hE;
    localparam logic [3:0] ST_SYS      = 4'hF;

    // meta event types
    localparam logic [7:0] META_LAST_TEXT = 8'h07;
    localparam logic [7:0] META_EOT       = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_TIMESIG   = 8'h58;
    localparam logic [7:0] META_KEYSIG    = 8'h59;
    localparam logic [7:0] META_SEQSPEC   = 8'h7F;

    typedef enum logic [1:0] {
        JOB_NOTE    = 2'd0,
        JOB_TEMPO   = 2'd1,
        JOB_SUMMARY = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic [TIME_W_MAX-1:0]  time_val;
        logic [7:0]             note;
        logic [7:0]             velocity;
        logic                   is_off;
        logic [15:0]            tpqn;
        logic [7:0]             flags;
        logic [7:0]             sig_num;
        logic [7:0]             sig_den;
        logic [15:0]            fmt;
        logic                   hdr_ok;
    } t_job;

    typedef struct packed {
        logic v0;
        logic v1;
        t_job j0;
        t_job j1;
    } t_push;

    typedef struct packed {
        logic        kind;
        logic [30:0] tick;
        logic [7:0]  note;
        logic [7:0]  velocity;
        logic        is_note_off;
        logic [7:0]  error_flags;
        logic [7:0]  time_sig_num;
        logic [7:0]  time_sig_den_exp;
        logic [25:0] bpm;
        logic [30:0] end_tick;
        logic [15:0] file_format;
        logic        last;
    } t_result;

    function automatic logic [7:0] hdr_id_byte(input logic [1:0] p);
        logic [7:0] r;
        case (p)
            2'd0:    r = 8'h4D;
            2'd1:    r = 8'h54;
            2'd2:    r = 8'h68;
            default: r = 8'h64;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] trk_id_byte(input logic [1:0] p);
        logic [7:0] r;
        case (p)
            2'd0:    r = 8'h4D;
            2'd1:    r = 8'h54;
            2'd2:    r = 8'h72;
            default: r = 8'h6B;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/mfne_in_if.sv
interface mfne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source(output valid, output file_byte, output end_of_file, input ready);
    modport sink(input valid, input file_byte, input end_of_file, output ready);
endinterface

>>> rtl/mfne_out_if.sv
interface mfne_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [30:0] tick;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic        is_note_off;
    logic [7:0]  error_flags;
    logic [7:0]  time_sig_num;
    logic [7:0]  time_sig_den_exp;
    logic [25:0] bpm;
    logic [30:0] end_tick;
    logic [15:0] file_format;
    logic        last;

    modport source(output valid, output kind, output tick, output note, output velocity,
                   output is_note_off, output error_flags, output time_sig_num,
                   output time_sig_den_exp, output bpm, output end_tick,
                   output file_format, output last, input ready);
    modport sink(input valid, input kind, input tick, input note, input velocity,
                 input is_note_off, input error_flags, input time_sig_num,
                 input time_sig_den_exp, input bpm, input end_tick,
                 input file_format, input last, output ready);
endinterface

>>> rtl/mfne_queue.sv
module mfne_queue
    import mfne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop,
    output t_job       o_head,
    output logic       o_avail,
    output logic       o_space,
    output logic [2:0] o_level
);
    t_job       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    // count pushes and pops of this cycle
    always_comb begin
        n_cnt = r_cnt + 3'(i_push.v0) + 3'(i_push.v1) - 3'(i_pop);
    end

    // store up to two jobs per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.j0;
        end
        if (i_push.v1) begin
            r_mem[r_wp + 2'd1] <= i_push.j1;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + 2'(i_push.v0) + 2'(i_push.v1);
            r_rp  <= r_rp + 2'(i_pop);
            r_cnt <= n_cnt;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_avail = (r_cnt != 3'd0);
    assign o_space = (r_cnt <= 3'd2);
    assign o_level = r_cnt;
endmodule

>>> rtl/mfne_front.sv
module mfne_front
    import mfne_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_res,
    input  logic        i_space,
    mfne_in_if.sink     i_in,
    output t_push       o_push
);
    typedef enum logic [11:0] {
        PH_HDR       = 12'h001,
        PH_TRKHDR    = 12'h002,
        PH_DELTA     = 12'h004,
        PH_STATUS    = 12'h008,
        PH_NOTE_KEY  = 12'h010,
        PH_NOTE_VEL  = 12'h020,
        PH_SKIP      = 12'h040,
        PH_META_TYPE = 12'h080,
        PH_META_LEN  = 12'h100,
        PH_TEMPO     = 12'h200,
        PH_EOT       = 12'h400,
        PH_DONE      = 12'h800
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [3:0]            r_pos, n_pos;
    logic [15:0]           r_tpqn, n_tpqn;
    logic [15:0]           r_total, n_total;
    logic [15:0]           r_done, n_done;
    logic [15:0]           r_fmt, n_fmt;
    logic [31:0]           r_left, n_left;
    logic [TIME_WIDTH-1:0] r_abs, n_abs;
    logic [TIME_WIDTH-1:0] r_delta, n_delta;
    logic [7:0]            r_rs, n_rs;
    logic [7:0]            r_cur, n_cur;
    logic [7:0]            r_pend, n_pend;
    logic [7:0]            r_skip, n_skip;
    logic [23:0]           r_tempo, n_tempo;
    logic                  r_cap, n_cap;
    logic                  r_hok, n_hok;
    logic                  r_any, n_any;
    logic [7:0]            r_err, n_err;
    logic [7:0]            r_num, n_num;
    logic [7:0]            r_den, n_den;

    logic       w_acc;
    logic [7:0] w_b;
    logic [7:0] w_cs;
    logic       w_off;
    logic       do_evt;
    logic       do_trk;
    t_job       w_job;
    t_job       w_sum;

    assign w_acc      = i_in.valid && i_space;
    assign w_b        = i_in.file_byte;
    assign i_in.ready = i_space;

    // parse one byte and build the jobs it causes
    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_tpqn = r_tpqn; n_total = r_total;
        n_done = r_done; n_fmt = r_fmt; n_left = r_left; n_abs = r_abs;
        n_delta = r_delta; n_rs = r_rs; n_cur = r_cur; n_pend = r_pend;
        n_skip = r_skip; n_tempo = r_tempo; n_cap = r_cap; n_hok = r_hok;
        n_any = r_any; n_err = r_err; n_num = r_num; n_den = r_den;
        do_evt = 1'b0;
        do_trk = 1'b0;
        w_cs   = w_b[7] ? w_b : r_rs;
        w_off  = (r_cur[7:4] == ST_NOTE_OFF);
        w_job  = '0;
        w_sum  = '0;
        o_push = '0;
        if (w_acc) begin
            // count down track bytes inside a track body
            if ((r_phase == PH_DELTA || r_phase == PH_STATUS || r_phase == PH_NOTE_KEY ||
                 r_phase == PH_NOTE_VEL || r_phase == PH_SKIP || r_phase == PH_META_TYPE ||
                 r_phase == PH_META_LEN || r_phase == PH_TEMPO || r_phase == PH_EOT) &&
                r_left != 32'd0) begin
                n_left = r_left - 32'd1;
            end
            unique case (r_phase)
                PH_HDR: begin
                    if (r_pos < 4'd4 && w_b != hdr_id_byte(r_pos[1:0])) begin
                        n_err   = r_err | E_FILE_ID;
                        n_phase = PH_DONE;
                    end else if (r_pos == 4'd7 && w_b != HDR_LEN) begin
                        n_err   = r_err | E_HDR_SIZE;
                        n_phase = PH_DONE;
                    end else begin
                        if (r_pos == 4'd7) n_hok = 1'b1;
                        if (r_pos == 4'd8 || r_pos == 4'd9) n_fmt = {r_fmt[7:0], w_b};
                        if (r_pos == 4'd10 || r_pos == 4'd11) n_total = {r_total[7:0], w_b};
                        if (r_pos == 4'd12 || r_pos == 4'd13) n_tpqn = {r_tpqn[7:0], w_b};
                        if (r_pos == 4'd13) begin
                            if (n_tpqn != i_res) n_err = r_err | E_RES;
                            n_pos   = '0;
                            n_phase = (r_total == 16'd0) ? PH_DONE : PH_TRKHDR;
                        end else begin
                            n_pos = r_pos + 4'd1;
                        end
                    end
                end
                PH_TRKHDR: begin
                    if (r_pos < 4'd4 && w_b != trk_id_byte(r_pos[1:0])) begin
                        n_err   = r_err | E_TRACK_ID | E_EMPTY;
                        n_phase = PH_DONE;
                    end else begin
                        if (r_pos >= 4'd4) n_left = {r_left[23:0], w_b};
                        if (r_pos == 4'd7) begin
                            n_abs   = '0;
                            n_delta = '0;
                            if (n_left == 32'd0) begin
                                n_err  = r_err | E_EMPTY;
                                do_trk = 1'b1;
                            end else begin
                                n_phase = PH_DELTA;
                            end
                        end else begin
                            n_pos = r_pos + 4'd1;
                        end
                    end
                end
                PH_DELTA: begin
                    n_delta = {r_delta[TIME_WIDTH-8:0], 7'b0} + TIME_WIDTH'(w_b[6:0]);
                    if (!w_b[7]) begin
                        n_abs   = r_abs + n_delta;
                        n_delta = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_cur = w_cs;
                    case (w_cs[7:4])
                        ST_NOTE_ON, ST_NOTE_OFF: begin
                            n_rs = w_cs;
                            if (w_b[7]) begin
                                n_phase = PH_NOTE_KEY;
                            end else begin
                                n_pend  = w_b;
                                n_phase = PH_NOTE_VEL;
                            end
                        end
                        ST_POLY, ST_CTRL, ST_BEND: begin
                            n_rs    = w_cs;
                            n_skip  = w_b[7] ? 8'd2 : 8'd1;
                            n_phase = PH_SKIP;
                        end
                        ST_PROG, ST_CHPR: begin
                            n_rs = w_cs;
                            if (w_b[7]) begin
                                n_skip  = 8'd1;
                                n_phase = PH_SKIP;
                            end else begin
                                do_evt = 1'b1;
                            end
                        end
                        ST_SYS: begin
                            n_rs    = '0;
                            n_phase = PH_META_TYPE;
                        end
                        default: begin
                            n_err  = r_err | E_UNKNOWN;
                            do_evt = 1'b1;
                        end
                    endcase
                end
                PH_NOTE_KEY: begin
                    n_pend  = w_b;
                    n_phase = PH_NOTE_VEL;
                end
                PH_NOTE_VEL: begin
                    w_job.kind     = JOB_NOTE;
                    w_job.time_val = TIME_W_MAX'(r_abs);
                    w_job.note     = r_pend;
                    w_job.velocity = w_off ? 8'd0 : w_b;
                    w_job.is_off   = w_off;
                    w_job.tpqn     = r_tpqn;
                    o_push.v0      = 1'b1;
                    o_push.j0      = w_job;
                    n_any          = 1'b1;
                    do_evt         = 1'b1;
                end
                PH_SKIP: begin
                    if (r_cap && r_skip == 8'd4) n_num = w_b;
                    if (r_cap && r_skip == 8'd3) n_den = w_b;
                    n_skip = r_skip - 8'd1;
                    if (n_skip == 8'd0) begin
                        n_cap  = 1'b0;
                        do_evt = 1'b1;
                    end
                end
                PH_META_TYPE: begin
                    if (w_b == META_TIMESIG) begin
                        n_cap   = 1'b1;
                        n_phase = PH_META_LEN;
                    end else if (w_b == META_TEMPO) begin
                        n_skip  = 8'd4;
                        n_tempo = '0;
                        n_phase = PH_TEMPO;
                    end else if (w_b <= META_LAST_TEXT || w_b == META_KEYSIG ||
                                 w_b == META_SEQSPEC) begin
                        n_cap   = 1'b0;
                        n_phase = PH_META_LEN;
                    end else if (w_b == META_EOT) begin
                        if (n_left == 32'd0) do_trk = 1'b1;
                        else n_phase = PH_EOT;
                    end else begin
                        do_evt = 1'b1;
                    end
                end
                PH_META_LEN: begin
                    if (w_b != 8'd4) n_cap = 1'b0;
                    if (w_b == 8'd0) begin
                        n_cap  = 1'b0;
                        do_evt = 1'b1;
                    end else begin
                        n_skip  = w_b;
                        n_phase = PH_SKIP;
                    end
                end
                PH_TEMPO: begin
                    n_skip = r_skip - 8'd1;
                    if (n_skip < 8'd3) n_tempo = {r_tempo[15:0], w_b};
                    if (n_skip == 8'd0) begin
                        w_job.kind     = JOB_TEMPO;
                        w_job.time_val = TIME_W_MAX'(n_tempo);
                        o_push.v0      = 1'b1;
                        o_push.j0      = w_job;
                        do_evt         = 1'b1;
                    end
                end
                PH_EOT: begin
                    if (n_left == 32'd0) do_trk = 1'b1;
                end
                PH_DONE: begin
                end
            endcase
            // close the event, then the track when its bytes are used up
            if (do_evt) begin
                if (n_left == 32'd0) do_trk = 1'b1;
                else n_phase = PH_DELTA;
            end
            if (do_trk) begin
                n_done = r_done + 16'd1;
                if (n_any || n_done >= r_total) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_TRKHDR;
                    n_pos   = '0;
                end
            end
            // queue the summary after any event and restart for the next file
            if (i_in.end_of_file) begin
                w_sum.kind    = JOB_SUMMARY;
                w_sum.flags   = n_err;
                w_sum.sig_num = n_num;
                w_sum.sig_den = n_den;
                w_sum.fmt     = n_fmt;
                w_sum.hdr_ok  = n_hok;
                if (o_push.v0) begin
                    o_push.v1 = 1'b1;
                    o_push.j1 = w_sum;
                end else begin
                    o_push.v0 = 1'b1;
                    o_push.j0 = w_sum;
                end
                n_phase = PH_HDR; n_pos = '0; n_tpqn = '0; n_total = '0;
                n_done = '0; n_fmt = '0; n_left = '0; n_abs = '0;
                n_delta = '0; n_rs = '0; n_cur = '0; n_pend = '0;
                n_skip = '0; n_tempo = '0; n_cap = 1'b0; n_hok = 1'b0;
                n_any = 1'b0; n_err = '0; n_num = '0; n_den = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_pos <= '0; r_tpqn <= '0; r_total <= '0;
            r_done <= '0; r_fmt <= '0; r_left <= '0; r_abs <= '0;
            r_delta <= '0; r_rs <= '0; r_cur <= '0; r_pend <= '0;
            r_skip <= '0; r_tempo <= '0; r_cap <= 1'b0; r_hok <= 1'b0;
            r_any <= 1'b0; r_err <= '0; r_num <= '0; r_den <= '0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_tpqn <= n_tpqn; r_total <= n_total;
            r_done <= n_done; r_fmt <= n_fmt; r_left <= n_left; r_abs <= n_abs;
            r_delta <= n_delta; r_rs <= n_rs; r_cur <= n_cur; r_pend <= n_pend;
            r_skip <= n_skip; r_tempo <= n_tempo; r_cap <= n_cap; r_hok <= n_hok;
            r_any <= n_any; r_err <= n_err; r_num <= n_num; r_den <= n_den;
        end
    end
endmodule

>>> rtl/mfne_back.sv
module mfne_back
    import mfne_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_res,
    input  t_job        i_head,
    input  logic        i_avail,
    output logic        o_pop,
    mfne_out_if.source  o_out
);
    localparam int DW    = TIME_WIDTH + 16;
    localparam int STEPS = (DW + 3) / 4;
    localparam int PADW  = STEPS * 4;
    localparam int DVW   = 25;
    localparam int RW    = DVW + 1;
    localparam int CW    = $clog2(STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state          r_state;
    t_job            r_job;
    logic [PADW-1:0] r_dq;
    logic [RW-1:0]   r_rem;
    logic [DVW-1:0]  r_div;
    logic [CW-1:0]   r_step;
    logic [25:0]     r_bpm;
    logic [1:0]      r_cnt;
    logic [30:0]     r_last_on;
    logic [30:0]     r_last_off;
    logic [30:0]     r_trim;
    logic            r_tv;
    logic            r_out_valid;
    t_result         r_out;

    logic [PADW-1:0] w_dq;
    logic [RW-1:0]   w_rem;
    logic [RW-1:0]   w_try;
    logic [DW-1:0]   w_prod;
    logic [30:0]     w_tick;
    logic            w_sat;
    logic            w_free;
    logic            w_fire;
    t_result         w_res;
    logic [7:0]      w_flags;
    logic [30:0]     w_end;

    // four restoring division steps per cycle
    always_comb begin
        w_dq  = r_dq;
        w_rem = r_rem;
        w_try = '0;
        for (int k = 0; k < 4; k++) begin
            w_try = {w_rem[RW-2:0], w_dq[PADW-1]};
            w_dq  = {w_dq[PADW-2:0], 1'b0};
            if (w_try >= {1'b0, r_div}) begin
                w_rem    = w_try - {1'b0, r_div};
                w_dq[0]  = 1'b1;
            end else begin
                w_rem = w_try;
            end
        end
    end

    assign w_prod = DW'(r_job.time_val[TIME_WIDTH-1:0]) * DW'(i_res);
    assign w_sat  = (r_job.tpqn == 16'd0) || (|r_dq[PADW-1:31]);
    assign w_tick = w_sat ? TICK_MAX : r_dq[30:0];
    assign w_free = !r_out_valid || o_out.ready;
    assign w_fire = (r_state == S_FIN) && w_free;
    assign o_pop  = (r_state == S_IDLE) && i_avail;

    // form the result of the finished job
    always_comb begin
        w_res   = '0;
        w_flags = r_job.flags;
        w_end   = '0;
        if (r_job.kind == JOB_SUMMARY) begin
            if (r_job.hdr_ok) begin
                if (r_cnt == 2'd0) begin
                    w_flags = w_flags | E_NO_EVENT;
                end else if (r_last_off < r_last_on) begin
                    w_flags = w_flags | E_NO_OFF;
                    if (r_cnt == 2'd1 || !r_tv) w_flags = w_flags | E_NO_EVENT;
                    else w_end = r_trim;
                end else begin
                    w_end = r_last_on;
                end
            end
            w_res.kind             = 1'b1;
            w_res.error_flags      = w_flags;
            w_res.time_sig_num     = r_job.sig_num;
            w_res.time_sig_den_exp = r_job.sig_den;
            w_res.bpm              = r_bpm;
            w_res.end_tick         = w_end;
            w_res.file_format      = r_job.fmt;
            w_res.last             = 1'b1;
        end else begin
            w_res.tick        = w_tick;
            w_res.note        = r_job.note;
            w_res.velocity    = r_job.velocity;
            w_res.is_note_off = r_job.is_off;
        end
    end

    // load the output when a job finishes, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bpm       <= '0;
            r_cnt       <= '0;
            r_last_on   <= '0;
            r_last_off  <= '0;
            r_trim      <= '0;
            r_tv        <= 1'b0;
            r_step      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_job <= i_head;
                        case (i_head.kind)
                            JOB_NOTE: begin
                                r_state <= (i_head.tpqn == 16'd0) ? S_FIN : S_MUL;
                            end
                            JOB_TEMPO: begin
                                if (i_head.time_val[23:0] == 24'd0) begin
                                    if (r_bpm == 26'd0) r_bpm <= BPM_ZERO;
                                end else begin
                                    r_dq    <= PADW'(BPM_NUM + 28'(i_head.time_val[23:0]));
                                    r_div   <= {i_head.time_val[23:0], 1'b0};
                                    r_rem   <= '0;
                                    r_step  <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_MUL: begin
                    r_dq    <= PADW'(w_prod);
                    r_div   <= DVW'(r_job.tpqn);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dq   <= w_dq;
                    r_rem  <= w_rem;
                    r_step <= r_step + CW'(1);
                    if (r_step == CW'(STEPS - 1)) begin
                        if (r_job.kind == JOB_TEMPO) begin
                            if (r_bpm == 26'd0) r_bpm <= w_dq[25:0];
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (w_free) begin
                        r_out       <= w_res;
                        r_state     <= S_IDLE;
                        if (r_job.kind == JOB_SUMMARY) begin
                            r_bpm      <= '0;
                            r_cnt      <= '0;
                            r_last_on  <= '0;
                            r_last_off <= '0;
                            r_trim     <= '0;
                            r_tv       <= 1'b0;
                        end else begin
                            if (r_job.is_off || r_job.velocity == 8'd0) begin
                                r_last_off <= w_tick;
                                r_trim     <= w_tick;
                                r_tv       <= 1'b1;
                            end else if (w_tick <= r_last_off) begin
                                r_trim <= w_tick;
                                r_tv   <= 1'b1;
                            end
                            if (!r_job.is_off) r_last_on <= w_tick;
                            if (r_cnt != 2'd2) r_cnt <= r_cnt + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.kind             = r_out.kind;
    assign o_out.tick             = r_out.tick;
    assign o_out.note             = r_out.note;
    assign o_out.velocity         = r_out.velocity;
    assign o_out.is_note_off      = r_out.is_note_off;
    assign o_out.error_flags      = r_out.error_flags;
    assign o_out.time_sig_num     = r_out.time_sig_num;
    assign o_out.time_sig_den_exp = r_out.time_sig_den_exp;
    assign o_out.bpm              = r_out.bpm;
    assign o_out.end_tick         = r_out.end_tick;
    assign o_out.file_format      = r_out.file_format;
    assign o_out.last             = r_out.last;
endmodule

>>> rtl/midi_file_note_extractor_core.sv
// Standard MIDI file note extractor. File bytes enter one per transaction on i_in; each
// note message yields a note transaction on o_out with its tick rescaled to the
// configured resolution, and the byte flagged end_of_file yields a summary transaction
// (error flags, time signature, first tempo in bpm, end tick, format) after which a new
// file may begin. The parser takes one byte per cycle as long as its four-entry job
// queue has two free slots. Each note with a nonzero file resolution then passes
// through the back end as one multiply, a radix-2 divider retiring four quotient bits
// per cycle, and a finish step; a tempo takes at most the divide, a summary only the
// finish, and the back end takes its next job only when done. That divider sets the
// sustained rate for note-dense input; other bytes flow at one per cycle while the queue
// has room. Write target_resolution on i_cfg_wr_en / i_cfg_wr_data only while the block is idle.
module midi_file_note_extractor_core
    import mfne_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    mfne_in_if.sink     i_in,
    mfne_out_if.source  o_out
);
    logic [15:0] r_target_res;
    t_push       w_push;
    t_job        w_head;
    logic        w_avail;
    logic        w_space;
    logic        w_pop;
    logic [2:0]  w_level;

    // hold the resolution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_res <= RES_AT_RESET;
        end else if (i_cfg_wr_en) begin
            r_target_res <= i_cfg_wr_data;
        end
    end

    mfne_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (r_target_res),
        .i_space (w_space),
        .i_in    (i_in),
        .o_push  (w_push)
    );

    mfne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_avail (w_avail),
        .o_space (w_space),
        .o_level (w_level)
    );

    mfne_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (r_target_res),
        .i_head  (w_head),
        .i_avail (w_avail),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= 3'd4)
        else $error("job queue overflow");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == o_out.kind))
        else $error("last flag differs from summary kind");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind) |-> (o_out.tick == 31'd0 && o_out.note == 8'd0))
        else $error("summary carries note fields");
`endif
endmodule
